// ----- sv/rpt_pkg.sv -----
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared constants and types of the rational packet timestamp core.
// ----------------------------------------------------------------------------
package rpt_pkg;

   localparam int RATE_W   = 40;
   localparam int QUANT_W  = 16;
   localparam int TIME_W   = 64;
   localparam int BYTES_W  = 16;
   localparam int SCALE_W  = 43;
   // packet time numerator width: bytes * 8e12 < 2^59
   localparam int PKT_W    = BYTES_W + SCALE_W;

   // numerator units per wire byte (8 bits times 1e12 ps)
   localparam logic [SCALE_W-1:0] PS_PER_BYTE = 43'd8000000000000;

   // register indexes of the control port
   localparam logic [1:0] CSR_LINK_RATE     = 2'd0;
   localparam logic [1:0] CSR_QUANTUM_BYTES = 2'd1;
   localparam logic [1:0] CSR_PATH_DELAY    = 2'd2;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_OVER_QUANTUM = 3'd1,
      STATUS_BAD_REMAINDER = 3'd2,
      STATUS_UNDERFLOW    = 3'd3,
      STATUS_OVERFLOW     = 3'd4
   } status_type;

endpackage

// ----- sv/rational_packet_timestamps_core.sv -----
// ----------------------------------------------------------------------------
// rational_packet_timestamps_core
// Exact ps timestamps of a packet whose slot end is a rational over the rate.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one packet word (wire bytes, slot end floor and remainder);
//  rsp_* returns one timestamp word per packet: source start, source end,
//  exit time, destination end and a status code. A word moves at a clock
//  edge with valid high and stall low.
//  csr_* writes link_rate, quantum_bytes and path_delay; csr_ready is always
//  high. Write registers only while the pipeline holds no packet.
//  Stages: input register, packet-time multiply feeding a
//  59-stage restoring divider (one quotient bit per stage, which sets the
//  depth), a sum stage and the output register. A new packet enters every
//  cycle unless req_stall is high, so throughput is one word per cycle.
//  Only the packet time is divided by the rate; the other ceilings follow
//  from the floor and remainder form of the slot end.
//  Reset clears all valid bits and loads the register reset values.
//  While rsp_stall holds a waiting word, the whole pipeline freezes and
//  req_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rational_packet_timestamps_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rpt_pkg::BYTES_W-1:0]   req_wire_bytes,
   input  logic [rpt_pkg::TIME_W-1:0]    req_end_floor,
   input  logic [rpt_pkg::RATE_W-1:0]    req_end_remainder,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rpt_pkg::TIME_W-1:0]    rsp_source_start,
   output logic [rpt_pkg::TIME_W-1:0]    rsp_source_end,
   output logic [rpt_pkg::TIME_W-1:0]    rsp_exit_time,
   output logic [rpt_pkg::TIME_W-1:0]    rsp_destination_end,
   output logic [2:0]                    rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [1:0]                    csr_index,
   input  logic [rpt_pkg::RATE_W-1:0]    csr_wdata
);
   import rpt_pkg::*;

   localparam int NSTEP = PKT_W;

   typedef struct packed {
      logic                  valid;
      logic [BYTES_W-1:0]    bytes;
      logic [TIME_W-1:0]     floor_v;
      logic [RATE_W-1:0]     rem_v;
   } in_type;

   typedef struct packed {
      logic                  valid;
      logic [PKT_W-1:0]      shq;     // dividend bits out, quotient bits in
      logic [RATE_W-1:0]     part;    // partial remainder
      logic [TIME_W-1:0]     floor_v;
      logic [RATE_W-1:0]     rem_v;
      logic                  over_q;
      logic                  bad_rem;
   } div_type;

   typedef struct packed {
      logic                  valid;
      logic                  over_q;
      logic                  bad_rem;
      logic                  under;
      logic [TIME_W:0]       start_v;
      logic [TIME_W:0]       end_v;
      logic [TIME_W+1:0]     exit_v;
      logic [TIME_W+1:0]     dest_v;
   } sum_type;

   logic [RATE_W-1:0]  rate_ff;
   logic [QUANT_W-1:0] quantum_ff;
   logic [RATE_W-1:0]  delay_ff;

   in_type  in_ff, in_in;
   div_type div_ff [0:NSTEP];
   div_type div_in [0:NSTEP];
   sum_type sum_ff, sum_in;

   logic               rsp_valid_ff;
   logic [TIME_W-1:0]  start_ff, end_ff, exit_ff, dest_ff;
   status_type         status_ff, status_in;

   logic advance;

   // pipeline moves unless a finished word is held
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign csr_ready = 1'b1;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= RATE_W'(1);
         quantum_ff <= QUANT_W'(4096);
         delay_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_LINK_RATE:     rate_ff    <= csr_wdata;
            CSR_QUANTUM_BYTES: quantum_ff <= csr_wdata[QUANT_W-1:0];
            CSR_PATH_DELAY:    delay_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input capture
   always_comb begin
      in_in.valid   = req_valid;
      in_in.bytes   = req_wire_bytes;
      in_in.floor_v = req_end_floor;
      in_in.rem_v   = req_end_remainder;
   end

   // packet time and range checks feed the divider,
   // then one restoring quotient bit per stage
   always_comb begin
      logic [RATE_W:0] cur;
      logic            qbit;
      div_in[0].valid   = in_ff.valid;
      div_in[0].shq     = PKT_W'(in_ff.bytes) * PKT_W'(PS_PER_BYTE);
      div_in[0].part    = '0;
      div_in[0].floor_v = in_ff.floor_v;
      div_in[0].rem_v   = in_ff.rem_v;
      div_in[0].over_q  = in_ff.bytes > quantum_ff;
      div_in[0].bad_rem = (rate_ff == '0) || (in_ff.rem_v >= rate_ff);
      for (int i = 0; i < NSTEP; i++) begin
         cur  = {div_ff[i].part, div_ff[i].shq[PKT_W-1]};
         qbit = cur >= {1'b0, rate_ff};
         div_in[i+1] = div_ff[i];
         div_in[i+1].shq = {div_ff[i].shq[PKT_W-2:0], qbit};
         if (qbit) begin
            div_in[i+1].part = RATE_W'(cur - {1'b0, rate_ff});
         end else begin
            div_in[i+1].part = cur[RATE_W-1:0];
         end
      end
   end

   // timestamps from floor, remainder and P = qp*R + rp
   always_comb begin
      logic [PKT_W-1:0]  qp;
      logic [RATE_W-1:0] rp;
      logic [TIME_W:0]   diff;
      logic [RATE_W:0]   rsum;
      logic [1:0]        kd;
      logic              nz;
      qp   = div_ff[NSTEP].shq;
      rp   = div_ff[NSTEP].part;
      nz   = div_ff[NSTEP].rem_v != '0;
      diff = {1'b0, div_ff[NSTEP].floor_v} - (TIME_W+1)'(qp);
      rsum = {1'b0, div_ff[NSTEP].rem_v} + {1'b0, rp};
      if (rsum == '0) begin
         kd = 2'd0;
      end else if (rsum <= {1'b0, rate_ff}) begin
         kd = 2'd1;
      end else begin
         kd = 2'd2;
      end
      sum_in.valid   = div_ff[NSTEP].valid;
      sum_in.over_q  = div_ff[NSTEP].over_q;
      sum_in.bad_rem = div_ff[NSTEP].bad_rem;
      sum_in.under   = diff[TIME_W] ||
                       (diff == '0 && div_ff[NSTEP].rem_v < rp);
      sum_in.start_v = diff + (TIME_W+1)'(div_ff[NSTEP].rem_v > rp);
      sum_in.end_v   = {1'b0, div_ff[NSTEP].floor_v} + (TIME_W+1)'(nz);
      sum_in.exit_v  = (TIME_W+2)'(div_ff[NSTEP].floor_v) + (TIME_W+2)'(delay_ff)
                     + (TIME_W+2)'(nz);
      sum_in.dest_v  = (TIME_W+2)'(div_ff[NSTEP].floor_v) + (TIME_W+2)'(delay_ff)
                     + (TIME_W+2)'(qp) + (TIME_W+2)'(kd);
   end

   // status in check order
   always_comb begin
      priority if (sum_ff.over_q) begin
         status_in = STATUS_OVER_QUANTUM;
      end else if (sum_ff.bad_rem) begin
         status_in = STATUS_BAD_REMAINDER;
      end else if (sum_ff.under) begin
         status_in = STATUS_UNDERFLOW;
      end else if (sum_ff.start_v[TIME_W] || sum_ff.end_v[TIME_W] ||
                   sum_ff.exit_v[TIME_W+1:TIME_W] != '0 ||
                   sum_ff.dest_v[TIME_W+1:TIME_W] != '0) begin
         status_in = STATUS_OVERFLOW;
      end else begin
         status_in = STATUS_OK;
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_ff.valid  <= 1'b0;
         for (int i = 0; i <= NSTEP; i++) begin
            div_ff[i].valid <= 1'b0;
         end
         sum_ff.valid <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         in_ff  <= in_in;
         for (int i = 0; i <= NSTEP; i++) begin
            div_ff[i] <= div_in[i];
         end
         sum_ff       <= sum_in;
         rsp_valid_ff <= sum_ff.valid;
      end
   end

   // output word, zeroed for a refused packet
   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= status_in;
         if (status_in == STATUS_OK) begin
            start_ff <= sum_ff.start_v[TIME_W-1:0];
            end_ff   <= sum_ff.end_v[TIME_W-1:0];
            exit_ff  <= sum_ff.exit_v[TIME_W-1:0];
            dest_ff  <= sum_ff.dest_v[TIME_W-1:0];
         end else begin
            start_ff <= '0;
            end_ff   <= '0;
            exit_ff  <= '0;
            dest_ff  <= '0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_source_start    = start_ff;
   assign rsp_source_end      = end_ff;
   assign rsp_exit_time       = exit_ff;
   assign rsp_destination_end = dest_ff;
   assign rsp_status          = status_ff;

   // refused packets carry no timestamps
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_source_start == '0 && rsp_source_end == '0 &&
         rsp_exit_time == '0 && rsp_destination_end == '0)
      else $error("refused packet with nonzero timestamps");

   // accepted packets keep time order
   a_time_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OK |->
         rsp_source_start <= rsp_source_end && rsp_source_end <= rsp_exit_time &&
         rsp_exit_time <= rsp_destination_end)
      else $error("timestamps out of order");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule
